### sv/ohm_pkg.sv
`default_nettype none
package ohm_pkg;

	localparam int CAPACITY   = 1024;
	localparam int KEY_BYTES  = 8;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int OCC_W      = 11;
	localparam int CHAIN_W    = 11;
	localparam int KEY_W      = 64;
	localparam int VAL_W      = 32;
	localparam int HASH_W     = 32;
	localparam int META_W     = 1 + CHAIN_W;
	localparam int DATA_W     = KEY_W + HASH_W + VAL_W;

	localparam int KEY_WORDS  = KEY_BYTES / 4;
	localparam int KEY_TAIL   = KEY_BYTES % 4;
	localparam int NFEED      = KEY_WORDS + KEY_TAIL;
	localparam int HASH_STEPS = NFEED * 4;
	localparam int HCNT_W     = $clog2(HASH_STEPS) + 1;

	localparam logic [CHAIN_W-1:0] CHAIN_MAX = '1;
	localparam logic [HASH_W-1:0]  CRC_POLY  = 32'h82F6_3B78;
	localparam logic [KEY_W-1:0]   KEY_MASK  = (KEY_BYTES >= 8) ? {KEY_W{1'b1}} :
		((64'd1 << (8 * KEY_BYTES)) - 64'd1);

	typedef enum logic [1:0] {
		ACT_PUT   = 2'd0,
		ACT_GET   = 2'd1,
		ACT_ERASE = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef struct packed {
		logic    load;
		logic    crc_step;
		logic    n_clr;
		logic    n_inc;
		logic    hit_save;
		logic    upd_we;
		logic    fin_we;
		logic    res_set;
		logic    res_found;
		status_t res_status;
		logic    res_hitval;
		logic    out_load;
		logic    clr_step;
	} cmd_t;

	typedef struct packed {
		action_t act;
		logic    hash_done;
		logic    busy;
		logic    hmatch;
		logic    kmatch;
		logic    chain_zero;
		logic    n_last;
		logic    n_zero;
		logic    upd_last;
		logic    clr_last;
		logic    out_free;
	} sts_t;

	// Eight reflected CRC32C shifts.
	function automatic logic [HASH_W-1:0] crc8(input logic [HASH_W-1:0] c);
		logic [HASH_W-1:0] r;
		r = c;
		for (int b = 0; b < 8; b++) begin
			r = (r >> 1) ^ (CRC_POLY & {HASH_W{r[0]}});
		end
		return r;
	endfunction

	// Word fed to the CRC: full little-endian words first, then single bytes.
	function automatic logic [HASH_W-1:0] feed_word(input logic [KEY_W-1:0] k, input int f);
		logic [HASH_W-1:0] w;
		if (f < KEY_WORDS) begin
			w = k[32*f +: 32];
		end else begin
			w = {24'd0, k[8*(4*KEY_WORDS + f - KEY_WORDS) +: 8]};
		end
		return w;
	endfunction

endpackage
`default_nettype wire

### sv/ohm_ram.sv
`default_nettype none
module ohm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

### sv/ohm_datapath.sv
`default_nettype none
module ohm_datapath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire ohm_pkg::cmd_t               cmd,
	output ohm_pkg::sts_t                    sts,
	input  wire logic [1:0]                  action,
	input  wire logic [ohm_pkg::KEY_W-1:0]   key,
	input  wire logic signed [ohm_pkg::VAL_W-1:0] value,
	input  wire logic                        rsp_stall,
	output logic                             rsp_valid,
	output logic                             found,
	output logic signed [ohm_pkg::VAL_W-1:0] value_read,
	output logic [1:0]                       status,
	output logic [ohm_pkg::OCC_W-1:0]        occupancy
);
	import ohm_pkg::*;

	action_t             act_q;
	logic [KEY_W-1:0]    key_q;
	logic [VAL_W-1:0]    val_q;
	logic [HASH_W-1:0]   crc_q;
	logic [HCNT_W-1:0]   fcnt_q;
	logic [IDX_W-1:0]    n_q;
	logic [IDX_W-1:0]    hitn_q;
	logic [CHAIN_W-1:0]  hitchain_q;
	logic [IDX_W-1:0]    clr_q;
	logic [OCC_W-1:0]    occ_q;
	logic                res_found_q;
	logic [VAL_W-1:0]    res_val_q;
	status_t             res_status_q;
	logic                out_valid_q;
	logic                out_found_q;
	logic [VAL_W-1:0]    out_val_q;
	status_t             out_status_q;
	logic [OCC_W-1:0]    out_occ_q;

	logic [HASH_W-1:0]   crc_in;
	logic [IDX_W-1:0]    probe_addr;
	logic [META_W-1:0]   meta_rd;
	logic [DATA_W-1:0]   data_rd;
	logic                busy_rd;
	logic [CHAIN_W-1:0]  chain_rd;
	logic [CHAIN_W-1:0]  chain_upd;
	logic [KEY_W-1:0]    dkey;
	logic [HASH_W-1:0]   dhash;
	logic [VAL_W-1:0]    dval;
	logic                meta_we;
	logic [IDX_W-1:0]    meta_waddr;
	logic [META_W-1:0]   meta_wdata;
	logic                data_we;

	assign probe_addr = crc_q[IDX_W-1:0] + n_q;
	assign busy_rd    = meta_rd[META_W-1];
	assign chain_rd   = meta_rd[CHAIN_W-1:0];
	assign dkey       = data_rd[DATA_W-1 -: KEY_W];
	assign dhash      = data_rd[VAL_W +: HASH_W];
	assign dval       = data_rd[VAL_W-1:0];

	assign crc_in = (fcnt_q[1:0] == 2'd0) ?
		(crc_q ^ feed_word(key_q, int'(fcnt_q >> 2))) : crc_q;

	always_comb begin
		if (act_q == ACT_PUT) begin
			chain_upd = (chain_rd == CHAIN_MAX) ? chain_rd : chain_rd + 1'b1;
		end else begin
			chain_upd = (chain_rd == '0) ? chain_rd : chain_rd - 1'b1;
		end
	end

	always_comb begin
		meta_we    = cmd.clr_step | cmd.upd_we | cmd.fin_we;
		meta_waddr = probe_addr;
		meta_wdata = {busy_rd, chain_upd};
		if (cmd.clr_step) begin
			meta_waddr = clr_q;
			meta_wdata = '0;
		end else if (cmd.fin_we) begin
			meta_wdata = {act_q == ACT_PUT, hitchain_q};
		end
	end

	assign data_we = cmd.fin_we && (act_q == ACT_PUT);

	ohm_ram #(.WIDTH(META_W), .DEPTH(CAPACITY)) u_meta (
		.clk   (clk),
		.we    (meta_we),
		.waddr (meta_waddr),
		.wdata (meta_wdata),
		.raddr (probe_addr),
		.rdata (meta_rd)
	);

	ohm_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_data (
		.clk   (clk),
		.we    (data_we),
		.waddr (probe_addr),
		.wdata ({key_q, crc_q, val_q}),
		.raddr (probe_addr),
		.rdata (data_rd)
	);

	always_comb begin
		sts.act        = act_q;
		sts.hash_done  = fcnt_q == HCNT_W'(HASH_STEPS - 1);
		sts.busy       = busy_rd;
		sts.hmatch     = busy_rd && (dhash == crc_q);
		sts.kmatch     = busy_rd && (dhash == crc_q) && (dkey == key_q);
		sts.chain_zero = chain_rd == '0;
		sts.n_last     = n_q == IDX_W'(CAPACITY - 1);
		sts.n_zero     = n_q == '0;
		sts.upd_last   = (n_q + 1'b1) == hitn_q;
		sts.clr_last   = clr_q == IDX_W'(CAPACITY - 1);
		sts.out_free   = !out_valid_q || !rsp_stall;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			occ_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.fin_we) begin
				if (act_q == ACT_PUT) begin
					occ_q <= occ_q + 1'b1;
				end else if (occ_q != '0) begin
					occ_q <= occ_q - 1'b1;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= action_t'(action);
			key_q  <= key & KEY_MASK;
			val_q  <= value;
			crc_q  <= '0;
			fcnt_q <= '0;
		end else if (cmd.crc_step) begin
			crc_q  <= crc8(crc_in);
			fcnt_q <= fcnt_q + 1'b1;
		end
		if (cmd.n_clr) begin
			n_q <= '0;
		end else if (cmd.n_inc) begin
			n_q <= n_q + 1'b1;
		end
		if (cmd.hit_save) begin
			hitn_q     <= n_q;
			hitchain_q <= chain_rd;
		end
		if (cmd.res_set) begin
			res_found_q  <= cmd.res_found;
			res_status_q <= cmd.res_status;
			res_val_q    <= cmd.res_hitval ? dval : '0;
		end
		if (cmd.out_load) begin
			out_found_q  <= res_found_q;
			out_val_q    <= res_val_q;
			out_status_q <= res_status_q;
			out_occ_q    <= occ_q;
		end
	end

	assign rsp_valid  = out_valid_q;
	assign found      = out_found_q;
	assign value_read = out_val_q;
	assign status     = out_status_q;
	assign occupancy  = out_occ_q;

endmodule
`default_nettype wire

### sv/ohm_ctrl.sv
`default_nettype none
module ohm_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire ohm_pkg::sts_t sts,
	output ohm_pkg::cmd_t      cmd
);
	import ohm_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_HASH, S_RD, S_CHK, S_URD, S_UWR, S_FIN, S_RES
	} state_t;

	state_t state_q, state_d;

	assign req_stall = state_q != S_IDLE;

	always_comb begin
		cmd        = '0;
		cmd.res_status = ST_DONE;
		state_d    = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_HASH;
				end
			end
			S_HASH: begin
				cmd.crc_step = 1'b1;
				if (sts.hash_done) begin
					if (sts.act == ACT_NOP) begin
						cmd.res_set = 1'b1;
						state_d     = S_RES;
					end else begin
						cmd.n_clr = 1'b1;
						state_d   = S_RD;
					end
				end
			end
			S_RD: begin
				state_d = S_CHK;
			end
			S_CHK: begin
				case (sts.act)
					ACT_PUT: begin
						if (!sts.busy) begin
							cmd.hit_save = 1'b1;
							if (sts.n_zero) begin
								state_d = S_FIN;
							end else begin
								cmd.n_clr = 1'b1;
								state_d   = S_URD;
							end
						end else if (sts.n_last) begin
							cmd.res_set    = 1'b1;
							cmd.res_status = ST_FULL;
							state_d        = S_RES;
						end else begin
							cmd.n_inc = 1'b1;
							state_d   = S_RD;
						end
					end
					ACT_GET: begin
						if (sts.kmatch) begin
							cmd.res_set    = 1'b1;
							cmd.res_found  = 1'b1;
							cmd.res_hitval = 1'b1;
							state_d        = S_RES;
						end else if ((!sts.hmatch && sts.chain_zero) || sts.n_last) begin
							cmd.res_set    = 1'b1;
							cmd.res_status = ST_MISS;
							state_d        = S_RES;
						end else begin
							cmd.n_inc = 1'b1;
							state_d   = S_RD;
						end
					end
					ACT_ERASE: begin
						if (sts.kmatch) begin
							cmd.hit_save = 1'b1;
							if (sts.n_zero) begin
								state_d = S_FIN;
							end else begin
								cmd.n_clr = 1'b1;
								state_d   = S_URD;
							end
						end else if (sts.n_last) begin
							cmd.res_set    = 1'b1;
							cmd.res_status = ST_MISS;
							state_d        = S_RES;
						end else begin
							cmd.n_inc = 1'b1;
							state_d   = S_RD;
						end
					end
					default: begin
						cmd.res_set = 1'b1;
						state_d     = S_RES;
					end
				endcase
			end
			S_URD: begin
				state_d = S_UWR;
			end
			S_UWR: begin
				// adjust the chain counter of one slot on the path, then advance
				cmd.upd_we = 1'b1;
				cmd.n_inc  = 1'b1;
				if (sts.upd_last) begin
					state_d = S_FIN;
				end else begin
					state_d = S_URD;
				end
			end
			S_FIN: begin
				cmd.fin_we    = 1'b1;
				cmd.res_set   = 1'b1;
				cmd.res_found = sts.act == ACT_ERASE;
				state_d       = S_RES;
			end
			S_RES: begin
				// hold until the output register frees up
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

### sv/open_addressing_hash_map_unit.sv
`default_nettype none
// channel  | handshake                | payload
// req      | req_valid / req_stall    | action, key, value
// rsp      | rsp_valid / rsp_stall    | found, value_read, status, occupancy
//
// One transaction at a time. Hashing runs one byte per cycle (CRC32C) over the key;
// each probed slot is a registered RAM read, then a compare; each chain counter
// on a put or erase path is read, then written back; accept, commit and result
// have states of their own. The next transaction can be accepted in the same cycle
// in which a result becomes valid.
// After reset a clearing pass over all 1024 slots zeroes busy bits and chain counters;
// req_stall stays high meanwhile. The result register frees the engine while rsp stalls.
module open_addressing_hash_map_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             req_valid,
	output logic                                  req_stall,
	input  wire logic [1:0]                       action,
	input  wire logic [ohm_pkg::KEY_W-1:0]        key,
	input  wire logic signed [ohm_pkg::VAL_W-1:0] value,
	output logic                                  rsp_valid,
	input  wire logic                             rsp_stall,
	output logic                                  found,
	output logic signed [ohm_pkg::VAL_W-1:0]      value_read,
	output logic [1:0]                            status,
	output logic [ohm_pkg::OCC_W-1:0]             occupancy
);
	import ohm_pkg::*;

	cmd_t cmd;
	sts_t sts;

	ohm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	ohm_datapath u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.action     (action),
		.key        (key),
		.value      (value),
		.rsp_stall  (rsp_stall),
		.rsp_valid  (rsp_valid),
		.found      (found),
		.value_read (value_read),
		.status     (status),
		.occupancy  (occupancy)
	);

endmodule
`default_nettype wire
